>>> rtl/assert_macros.svh
// Assertion macros shared by the moving-window RMS RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define MWR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define MWR_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define MWR_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/mwr_pkg.sv
// Shared constants and types of the moving-window RMS block.
package mwr_pkg;

  // Width of the window length register and of the RMS result.
  localparam int LEN_W = 7;
  localparam int RMS_W = 16;

  // Window length after reset.
  localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 7'd20;

  // Status of the divide and root unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mwr_root_status_t;

endpackage

>>> rtl/moving_window_rms_unit.sv
// Moving-window RMS: delay line, running sum of squares and root sequencer.
`include "assert_macros.svh"

// Each accepted sample enters a delay line of up to WINDOW_MAX entries and
// updates a running sum of squares over the last window_len samples. Once the
// window has filled since the last clear, every sample yields
// rms = floor(sqrt(floor(sum / window_len))); before that no result is given.
// frame_start clears the window before its sample is taken, and a write of
// window_len clears it as well (length 0 acts as 1, lengths above WINDOW_MAX
// act as WINDOW_MAX). One shared squarer updates the sum and one shared
// subtractor runs a bit-serial divide and root, one bit per cycle. A sample
// holds the input while it is read, squared and added to the sum; one that
// gives a result also holds it through 2*SAMPLE_BITS+5 divide steps and
// SAMPLE_BITS+3 root steps until its result is loaded. The finished result
// waits in an output register, so the next sample may enter while it is pending.
// The delay line needs no clearing pass after reset.
module moving_window_rms_unit #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            window_len_we,
  input  logic [mwr_pkg::LEN_W-1:0]       window_len,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic signed [SAMPLE_BITS-1:0]   sample,
  input  logic                            frame_start,
  output logic                            rms_valid,
  input  logic                            rms_stall,
  output logic [mwr_pkg::RMS_W-1:0]       rms
);

  import mwr_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW_MAX);
  localparam int SUM_W  = 2 * SAMPLE_BITS + 5;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int CW     = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SQOLD,
    S_SUBOLD,
    S_SQNEW,
    S_ADD,
    S_START,
    S_WAIT,
    S_OUT
  } state_t;

  state_t                  state;
  logic [LEN_W-1:0]        win_len;
  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        fill;
  logic [PTR_W-1:0]        wp;
  logic [SUM_W-1:0]        sum;
  logic [SQ_W-1:0]         square;
  logic [SAMPLE_BITS-1:0]  raw;
  logic [SAMPLE_BITS-1:0]  rd_data;
  logic [SAMPLE_BITS-1:0]  sq_in;
  logic [SAMPLE_BITS-1:0]  sq_mag;
  logic [SQ_W-1:0]         sq_prod;
  logic [CW-1:0]           wp_ext;
  logic [CW-1:0]           len_ext;
  logic [CW-1:0]           old_ext;
  logic [PTR_W-1:0]        rd_addr;
  logic                    root_start;
  mwr_root_status_t        root_status;
  logic [ROOT_W-1:0]       root;
  logic                    accept;

  logic [SAMPLE_BITS-1:0]  window_mem [WINDOW_MAX];

  // Clamp the programmed length to the delay line
  always_comb begin
    if (win_len == '0) begin
      len = LEN_W'(1);
    end else if (32'(win_len) > WINDOW_MAX) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = win_len;
    end
  end

  // Locate the sample that leaves the window
  always_comb begin
    wp_ext  = CW'(wp);
    len_ext = CW'(len);
    if (wp_ext >= len_ext) begin
      old_ext = wp_ext - len_ext;
    end else begin
      old_ext = wp_ext + CW'(WINDOW_MAX) - len_ext;
    end
    rd_addr = old_ext[PTR_W-1:0];
  end

  // Square the leaving or the arriving sample on one multiplier
  always_comb begin
    sq_in   = (state == S_SQOLD) ? rd_data : raw;
    sq_mag  = sq_in[SAMPLE_BITS-1] ? (~sq_in + 1'b1) : sq_in;
    sq_prod = sq_mag * sq_mag;
  end

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != S_IDLE);
  assign root_start   = (state == S_START);

  // Read the leaving sample, write the arriving one
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_data <= window_mem[rd_addr];
    end
    if (state == S_SQNEW) begin
      window_mem[wp] <= raw;
    end
  end

  // Sequence one request and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      win_len   <= WINDOW_LEN_RESET;
      fill      <= '0;
      wp        <= '0;
      sum       <= '0;
      rms_valid <= 1'b0;
    end else begin
      if (rms_valid && !rms_stall) begin
        rms_valid <= 1'b0;
      end
      if (window_len_we) begin
        win_len <= window_len;
        fill    <= '0;
        wp      <= '0;
        sum     <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            raw <= sample;
            if (frame_start) begin
              fill <= '0;
              wp   <= '0;
              sum  <= '0;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_SQOLD;
        end
        S_SQOLD: begin
          square <= sq_prod;
          state  <= S_SUBOLD;
        end
        S_SUBOLD: begin
          if (fill >= len) begin
            sum <= sum - SUM_W'(square);
          end else begin
            fill <= fill + 1'b1;
          end
          state <= S_SQNEW;
        end
        S_SQNEW: begin
          square <= sq_prod;
          state  <= S_ADD;
        end
        S_ADD: begin
          sum <= sum + SUM_W'(square);
          if (wp == PTR_W'(WINDOW_MAX - 1)) begin
            wp <= '0;
          end else begin
            wp <= wp + 1'b1;
          end
          state <= (fill < len) ? S_IDLE : S_START;
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (root_status.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rms_valid || !rms_stall) begin
            rms       <= RMS_W'(root);
            rms_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  mwr_root_unit #(
    .SUM_W (SUM_W)
  ) u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .dividend (sum),
    .divisor  (len),
    .status   (root_status),
    .root     (root)
  );

  `MWR_ASSERT(a_fill_bound, fill <= len, "fill count exceeds window length")
  `MWR_ASSERT_IMP(a_done_in_wait, root_status.done, state == S_WAIT, "root done outside wait")
  `MWR_ASSERT_IMP(a_start_free, root_start, !root_status.busy, "root unit restarted while busy")
  `MWR_ASSERT_NXT(a_out_load, state == S_OUT && !(rms_valid && rms_stall), rms_valid && state == S_IDLE, "result not loaded")

endmodule

>>> rtl/mwr_root_unit.sv
// Iterative divide then square root unit sharing one trial subtractor.
`include "assert_macros.svh"

module mwr_root_unit #(
  parameter int SUM_W = 37
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SUM_W-1:0]             dividend,
  input  logic [mwr_pkg::LEN_W-1:0]    divisor,
  output mwr_pkg::mwr_root_status_t    status,
  output logic [(SUM_W+1)/2-1:0]       root
);

  import mwr_pkg::*;

  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int QW     = 2 * ROOT_W;
  // Root remainder stays at or below twice the partial root.
  localparam int REM_W  = ROOT_W + 2;
  // Trial width covers the root step, which always exceeds the divide step.
  localparam int SW     = REM_W + 2;
  localparam int CNT_W  = $clog2(SUM_W);

  typedef enum logic [1:0] {
    R_IDLE,
    R_DIV,
    R_SQRT
  } phase_t;

  phase_t             phase;
  logic [QW-1:0]      q;
  logic [REM_W-1:0]   rem;
  logic [LEN_W-1:0]   div_len;
  logic [CNT_W-1:0]   count;
  logic               done;
  logic [SW-1:0]      sub_a;
  logic [SW-1:0]      sub_b;
  logic [SW:0]        sub_res;
  logic               ok;

  // Select trial operands for the shared subtractor
  always_comb begin
    if (phase == R_SQRT) begin
      sub_a = {rem, q[QW-1:QW-2]};
      sub_b = SW'({root, 2'b01});
    end else begin
      sub_a = SW'({rem[LEN_W-1:0], q[QW-1]});
      sub_b = SW'(div_len);
    end
    sub_res = {1'b0, sub_a} - {1'b0, sub_b};
    ok      = !sub_res[SW];
  end

  // Step the divide, then the root, one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        R_IDLE: begin
          if (start) begin
            q       <= QW'(dividend) << (QW - SUM_W);
            rem     <= '0;
            div_len <= divisor;
            count   <= CNT_W'(SUM_W - 1);
            phase   <= R_DIV;
          end
        end
        R_DIV: begin
          q   <= {q[QW-2:0], ok};
          rem <= ok ? REM_W'(sub_res[SW-1:0]) : REM_W'(sub_a);
          if (count == '0) begin
            rem   <= '0;
            root  <= '0;
            count <= CNT_W'(ROOT_W - 1);
            phase <= R_SQRT;
          end else begin
            count <= count - 1'b1;
          end
        end
        R_SQRT: begin
          q    <= q << 2;
          rem  <= ok ? REM_W'(sub_res[SW-1:0]) : REM_W'(sub_a);
          root <= {root[ROOT_W-2:0], ok};
          if (count == '0) begin
            done  <= 1'b1;
            phase <= R_IDLE;
          end else begin
            count <= count - 1'b1;
          end
        end
        default: begin
          phase <= R_IDLE;
        end
      endcase
    end
  end

  assign status.busy = (phase != R_IDLE);
  assign status.done = done;

  `MWR_ASSERT_IMP(a_start_when_idle, start, phase == R_IDLE, "root unit started while busy")
  `MWR_ASSERT_NXT(a_done_after_last, phase == R_SQRT && count == '0, done && phase == R_IDLE, "root unit missed done")

endmodule

>>> dv/tb.sv
// Self-checking testbench of the moving-window RMS unit.
`timescale 1ns / 100ps

module tb;
  import mwr_pkg::*;

  localparam int WIN_MAX     = 64;
  localparam int HOLD_CYCLES = 100;
  localparam int IDLE_LIMIT  = 5000;
  localparam int ITEM_TARGET = 2000;
  localparam int NUM_STEPS   = 14;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  // One row of the directed sequence: a length write or a run of equal requests.
  typedef struct packed {
    row_kind_t        kind;
    logic [LEN_W-1:0] len;
    logic [15:0]      smp;
    logic             fs;
    logic [4:0]       rep;
    logic             chk;
    logic [RMS_W-1:0] rms;
  } step_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    window_len_we = 1'b0;
  logic [LEN_W-1:0]        window_len = '0;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic signed [15:0]      sample = '0;
  logic                    frame_start = 1'b0;
  logic                    rms_valid;
  logic                    rms_stall = 1'b0;
  logic [RMS_W-1:0]        rms;

  // Predictor state
  logic [LEN_W-1:0]        model_len;
  logic [15:0]             model_win [WIN_MAX];
  logic [63:0]             model_sum;
  int unsigned             model_fill;
  int unsigned             model_wptr;

  logic [RMS_W-1:0]        pending_rms [$];
  step_t                   steps [NUM_STEPS];
  bit                      calm = 1'b0;
  int                      err_count = 0;
  int                      sent_count = 0;
  int                      checked_count = 0;
  int                      cfg_count = 0;
  int                      hold_left = 0;
  int                      idle_cycles = 0;

  moving_window_rms_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .window_len_we(window_len_we),
    .window_len   (window_len),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .frame_start  (frame_start),
    .rms_valid    (rms_valid),
    .rms_stall    (rms_stall),
    .rms          (rms)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap length: mostly none or short, a few long; none during calm stretches.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic int unsigned active_len(input logic [LEN_W-1:0] l);
    if (l == 0) return 1;
    if (l > WIN_MAX) return WIN_MAX;
    return 32'(l);
  endfunction

  function automatic logic [63:0] square_mag(input logic [15:0] raw);
    logic [16:0] mag;
    mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    return 64'(mag) * 64'(mag);
  endfunction

  // Build the root one bit at a time from the top.
  function automatic logic [RMS_W-1:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[RMS_W-1:0];
  endfunction

  task automatic clear_model();
    for (int i = 0; i < WIN_MAX; i++) model_win[i] = '0;
    model_sum = '0;
    model_fill = 0;
    model_wptr = 0;
  endtask

  // Advance the window by one request and compute the RMS it yields, if any.
  task automatic rms_predict(input logic [15:0] raw, input logic fs,
                             output bit got, output logic [RMS_W-1:0] val);
    int unsigned n;
    int unsigned old;
    n = active_len(model_len);
    if (fs) clear_model();
    if (model_fill >= n) begin
      old = (model_wptr >= n) ? model_wptr - n : model_wptr + WIN_MAX - n;
      model_sum -= square_mag(model_win[old]);
    end else begin
      model_fill++;
    end
    model_sum += square_mag(raw);
    model_win[model_wptr] = raw;
    model_wptr = (model_wptr + 1) % WIN_MAX;
    got = (model_fill >= n);
    val = got ? floor_root(model_sum / n) : '0;
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  // Present one request after a random gap and hold it until accepted.
  task automatic send_sample(input logic [15:0] raw, input logic fs,
                             input logic chk, input logic [RMS_W-1:0] typed);
    int gap;
    bit got;
    logic [RMS_W-1:0] val;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= raw;
    frame_start <= fs;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    rms_predict(raw, fs, got, val);
    if (got) pending_rms.push_back(chk ? typed : val);
    sent_count++;
  endtask

  // Write the window length once the block has drained and gone quiet.
  task automatic set_window(input logic [LEN_W-1:0] v);
    sample_valid <= 1'b0;
    while (pending_rms.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
    window_len_we <= 1'b1;
    window_len <= v;
    @(posedge clk);
    window_len_we <= 1'b0;
    model_len = v;
    clear_model();
    cfg_count++;
  endtask

  function automatic logic [15:0] draw_sample(input bit full_scale);
    int r;
    if (full_scale) return 16'h8000;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom);
    if (r == 6) begin
      case ($urandom_range(0, 4))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    return 16'($urandom_range(0, 255) - 128);
  endfunction

  function automatic logic [LEN_W-1:0] draw_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 6))
        0: return 7'd0;
        1: return 7'd1;
        2: return 7'd2;
        3: return 7'd63;
        4: return 7'd64;
        5: return 7'd65;
        default: return 7'd127;
      endcase
    end
    if (r == 9) return LEN_W'($urandom_range(25, 64));
    return LEN_W'($urandom_range(1, 24));
  endfunction

  // Check each accepted result and stall the output at random.
  always @(posedge clk) begin
    if (!rst && rms_valid && !rms_stall) begin
      if (pending_rms.size() == 0) begin
        report_mismatch($sformatf("rms %0d with nothing expected", rms));
      end else begin
        if (rms !== pending_rms[0])
          report_mismatch($sformatf("rms %0d, expected %0d", rms, pending_rms[0]));
        void'(pending_rms.pop_front());
        checked_count++;
      end
    end
    if (hold_left > 0) begin
      rms_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      hold_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      rms_stall <= (hold_left > 0);
      if (hold_left > 0) hold_left = hold_left - 1;
    end
  end

  // Stop the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (rms_valid && !rms_stall)
        || window_len_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned n;
    bit full_scale;
    model_len = WINDOW_LEN_RESET;
    clear_model();
    steps = '{
      // reset length: full-scale negative fills the window, peak result
      '{ROW_SAMPLE, 7'd0,   16'h8000, 1'b0, 5'd20, 1'b1, 16'h8000},
      '{ROW_CFG,    7'd1,   16'h0000, 1'b0, 5'd0,  1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'h7FFF, 1'b0, 5'd1,  1'b1, 16'h7FFF},
      '{ROW_SAMPLE, 7'd0,   16'h0000, 1'b0, 5'd1,  1'b1, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'hFFFF, 1'b0, 5'd1,  1'b1, 16'h0001},
      // zero length acts as one
      '{ROW_CFG,    7'd0,   16'h0000, 1'b0, 5'd0,  1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'h0001, 1'b1, 5'd1,  1'b1, 16'h0001},
      '{ROW_CFG,    7'd2,   16'h0000, 1'b0, 5'd0,  1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'h0003, 1'b0, 5'd1,  1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'h0004, 1'b0, 5'd1,  1'b1, 16'h0003},
      // frame start restarts the fill
      '{ROW_SAMPLE, 7'd0,   16'h0005, 1'b1, 5'd1,  1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'h0007, 1'b0, 5'd1,  1'b1, 16'h0006},
      // oversized length acts as the maximum
      '{ROW_CFG,    7'd127, 16'h0000, 1'b0, 5'd0,  1'b0, 16'h0000},
      '{ROW_SAMPLE, 7'd0,   16'h8000, 1'b1, 5'd1,  1'b0, 16'h0000}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed rows.
    for (int i = 0; i < NUM_STEPS; i++) begin
      if (steps[i].kind == ROW_CFG) begin
        set_window(steps[i].len);
      end else begin
        repeat (steps[i].rep) send_sample(steps[i].smp, steps[i].fs, steps[i].chk, steps[i].rms);
      end
    end

    // Random phases: new length, fill the window, then a run of results.
    while (sent_count < ITEM_TARGET) begin
      set_window(draw_len());
      calm = ($urandom_range(0, 4) == 0);
      full_scale = ($urandom_range(0, 7) == 0);
      n = active_len(model_len) + $urandom_range(4, 40);
      repeat (n) send_sample(draw_sample(full_scale), $urandom_range(0, 39) == 0, 1'b0, '0);
    end
    calm = 1'b0;

    // Drain and let the block settle.
    sample_valid <= 1'b0;
    while (pending_rms.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);

    $display("covered %0d requests under %0d window length writes", sent_count, cfg_count);
    $display("compared %0d rms results, %0d mismatches", checked_count, err_count);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
